// ----- src/switch_debounce_edge_hold_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the switch debouncer
// Shared concurrent-assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SWITCH_DEBOUNCE_EDGE_HOLD_DEFINES_SVH
`define SWITCH_DEBOUNCE_EDGE_HOLD_DEFINES_SVH

// Same-cycle implication
`define SDEH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdeh assertion failed");

// Next-cycle implication
`define SDEH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdeh assertion failed");

`endif

// ----- src/sdeh_pkg.sv -----
// ----------------------------------------------------------------------------
// sdeh_pkg
// Types, operation codes and reset constants of the switch debouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdeh_pkg;

  localparam int unsigned NUM_SWITCHES_DEF = 4;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned RAW_W  = 4;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned SWNUM_W = 4;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned PER_W  = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_SAMPLE     = 3'd0;
  localparam logic [OP_W-1:0] OP_READ_STATE = 3'd1;
  localparam logic [OP_W-1:0] OP_READ_RISE  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ_FALL  = 3'd3;
  localparam logic [OP_W-1:0] OP_HOLD_TEST  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_TOP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 1'd1;

  localparam logic [CNT_W-1:0]  COUNTER_TOP_RST   = 8'd5;
  localparam logic [PER_W-1:0]  SAMPLE_PERIOD_RST = 16'd5;
  localparam logic [TIME_W-1:0] HOLD_NONE         = '1;

  // Per-switch debounce state
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic              active;
    logic              rise;
    logic              fall;
    logic [TIME_W-1:0] hold_start;
  } sdeh_sw_t;

endpackage

`default_nettype wire

// ----- src/sdeh_unit.sv -----
// ----------------------------------------------------------------------------
// sdeh_unit
// Shared update unit: steps one switch for a sample or answers one query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdeh_unit (
  input  logic [sdeh_pkg::OP_W-1:0]   op,
  input  logic                        pressed,
  input  logic [sdeh_pkg::CNT_W-1:0]  counter_top,
  input  logic [sdeh_pkg::TIME_W-1:0] time_now,
  input  logic [sdeh_pkg::TIME_W-1:0] hold_ms,
  input  sdeh_pkg::sdeh_sw_t          sw_in,
  output sdeh_pkg::sdeh_sw_t          sw_out,
  output logic                        answer
);

  logic [sdeh_pkg::CNT_W-1:0]  cnt;
  logic [sdeh_pkg::TIME_W-1:0] elapsed;

  assign elapsed = time_now - hold_ms;

  always_comb begin
    sw_out = sw_in;
    answer = 1'b0;
    cnt    = sw_in.count;
    unique case (op)
      sdeh_pkg::OP_SAMPLE: begin
        // Saturating integrator step
        if (pressed) begin
          if (sw_in.count < counter_top) cnt = sw_in.count + 8'd1;
        end else begin
          if (sw_in.count != '0) cnt = sw_in.count - 8'd1;
        end
        sw_out.count = cnt;
        if (cnt >= counter_top) begin
          if (!sw_in.active) begin
            sw_out.rise       = 1'b1;
            sw_out.fall       = 1'b0;
            sw_out.hold_start = time_now;
          end
          sw_out.active = 1'b1;
        end else if (cnt == '0) begin
          if (sw_in.active) begin
            sw_out.rise       = 1'b0;
            sw_out.fall       = 1'b1;
            sw_out.hold_start = sdeh_pkg::HOLD_NONE;
          end
          sw_out.active = 1'b0;
        end
      end
      sdeh_pkg::OP_READ_STATE: answer = sw_in.active;
      sdeh_pkg::OP_READ_RISE: begin
        answer      = sw_in.rise;
        sw_out.rise = 1'b0;
      end
      sdeh_pkg::OP_READ_FALL: begin
        answer      = sw_in.fall;
        sw_out.fall = 1'b0;
      end
      sdeh_pkg::OP_HOLD_TEST: begin
        if (sw_in.active && (time_now >= hold_ms) && (elapsed > sw_in.hold_start)) begin
          sw_out.hold_start = time_now;
          answer            = 1'b1;
        end
      end
      default: answer = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/switch_debounce_edge_hold.sv -----
// ----------------------------------------------------------------------------
// switch_debounce_edge_hold
// Integrating-counter debouncer with edge latches and a hold-time test.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_* and raise start; the transaction is taken at
//   a clock edge with start high and busy low. busy stays high while the
//   item is worked on.
//   Result channel: out_valid is high for exactly one cycle with out_answer
//   and out_debounced_states; the receiver cannot stall, so every result
//   must be taken in that cycle.
//   Configuration: cfg_valid/cfg_ready write counter_top (index 0) or
//   sample_period (index 1); write only while the block is idle.
// Operation:
//   A sample that is applied walks the switches through one shared update
//   unit, one switch per cycle, in ST_LOOP after ST_CHECK.
//   A valid query uses the unit once, in ST_QUERY after ST_CHECK.
//   A skipped sample, bad switch number or unused code ends in ST_CHECK.
//   A new command is taken in the cycle its predecessor's result shows.
// Reset: rst_n (synchronous, active low) clears all integrators, flags and
//   the sample timer, sets hold starts to all ones and the registers to 5.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "switch_debounce_edge_hold_defines.svh"

module switch_debounce_edge_hold #(
  parameter int unsigned NUM_SWITCHES = sdeh_pkg::NUM_SWITCHES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [sdeh_pkg::OP_W-1:0]         in_operation,
  input  logic [sdeh_pkg::RAW_W-1:0]        in_raw_levels,
  input  logic [sdeh_pkg::TIME_W-1:0]       in_time_now,
  input  logic [sdeh_pkg::SWNUM_W-1:0]      in_switch_number,
  input  logic [sdeh_pkg::TIME_W-1:0]       in_hold_ms,
  // Result channel
  output logic                              out_valid,
  output logic                              out_answer,
  output logic [sdeh_pkg::RAW_W-1:0]        out_debounced_states,
  // Configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sdeh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdeh_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_LOOP  = 2'd2;
  localparam logic [1:0] ST_QUERY = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // Captured command
  logic [sdeh_pkg::OP_W-1:0]    op_r;
  logic [sdeh_pkg::RAW_W-1:0]   raw_r;
  logic [sdeh_pkg::TIME_W-1:0]  now_r;
  logic [sdeh_pkg::SWNUM_W-1:0] swnum_r;
  logic [sdeh_pkg::TIME_W-1:0]  hold_r;

  // Configuration and timer
  logic [sdeh_pkg::CNT_W-1:0]  counter_top_r;
  logic [sdeh_pkg::PER_W-1:0]  sample_period_r;
  logic [sdeh_pkg::TIME_W-1:0] next_sample_r, next_sample_nxt;

  // Per-switch state
  sdeh_pkg::sdeh_sw_t sw_r [NUM_SWITCHES];

  // Result registers
  logic                       out_valid_r;
  logic                       out_answer_r;
  logic [sdeh_pkg::RAW_W-1:0] out_states_r;

  logic                       accept;
  logic                       step;
  logic                       done;
  logic                       query_ok;
  logic [sdeh_pkg::SWNUM_W-1:0] idx_ext;
  logic                       pressed;
  logic                       unit_answer;
  sdeh_pkg::sdeh_sw_t         unit_out;
  logic [sdeh_pkg::RAW_W-1:0] states_nxt;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;

  // Only switches 1..4 have a raw input; the rest read as released
  assign idx_ext = sdeh_pkg::SWNUM_W'(idx_r);
  assign pressed = (idx_ext < 4'd4) && raw_r[idx_ext[1:0]];

  assign query_ok = (op_r >= sdeh_pkg::OP_READ_STATE) && (op_r <= sdeh_pkg::OP_HOLD_TEST) &&
                    (swnum_r >= 4'd1) &&
                    (swnum_r <= sdeh_pkg::SWNUM_W'(NUM_SWITCHES));

  sdeh_unit u_unit (
    .op          (op_r),
    .pressed     (pressed),
    .counter_top (counter_top_r),
    .time_now    (now_r),
    .hold_ms     (hold_r),
    .sw_in       (sw_r[idx_r]),
    .sw_out      (unit_out),
    .answer      (unit_answer)
  );

  // Sequencer: check the command, then walk or touch one switch
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    next_sample_nxt = next_sample_r;
    step            = 1'b0;
    done            = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (op_r == sdeh_pkg::OP_SAMPLE) begin
          if (now_r > next_sample_r) begin
            next_sample_nxt = now_r + sdeh_pkg::TIME_W'(sample_period_r);
            idx_nxt         = '0;
            state_nxt       = ST_LOOP;
          end else begin
            done      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (query_ok) begin
          idx_nxt   = IDX_W'(swnum_r - 4'd1);
          state_nxt = ST_QUERY;
        end else begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_LOOP: begin
        step = 1'b1;
        if (idx_r == IDX_W'(NUM_SWITCHES - 1)) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_QUERY: begin
        step      = 1'b1;
        done      = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Debounced flags as they stand after this cycle's update
  for (genvar g = 0; g < sdeh_pkg::RAW_W; g++) begin : g_states
    if (g < NUM_SWITCHES) begin : g_real
      assign states_nxt[g] = (step && (idx_r == IDX_W'(g))) ? unit_out.active
                                                             : sw_r[g].active;
    end else begin : g_none
      assign states_nxt[g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      idx_r           <= '0;
      next_sample_r   <= '0;
      counter_top_r   <= sdeh_pkg::COUNTER_TOP_RST;
      sample_period_r <= sdeh_pkg::SAMPLE_PERIOD_RST;
      out_valid_r     <= 1'b0;
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        sw_r[i].count      <= '0;
        sw_r[i].active     <= 1'b0;
        sw_r[i].rise       <= 1'b0;
        sw_r[i].fall       <= 1'b0;
        sw_r[i].hold_start <= sdeh_pkg::HOLD_NONE;
      end
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      next_sample_r <= next_sample_nxt;
      out_valid_r   <= done;
      // Write back the switch the unit just handled
      if (step) sw_r[idx_r] <= unit_out;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sdeh_pkg::REG_COUNTER_TOP) begin
          counter_top_r <= cfg_data[sdeh_pkg::CNT_W-1:0];
        end else if (cfg_index == sdeh_pkg::REG_SAMPLE_PERIOD) begin
          sample_period_r <= cfg_data;
        end
      end
    end
  end

  // Payload: capture the command on accept, the result on completion
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_operation;
      raw_r   <= in_raw_levels;
      now_r   <= in_time_now;
      swnum_r <= in_switch_number;
      hold_r  <= in_hold_ms;
    end
    if (done) begin
      out_answer_r <= (state_r == ST_QUERY) ? unit_answer : 1'b0;
      out_states_r <= states_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_answer           = out_answer_r;
  assign out_debounced_states = out_states_r;

  // Checks
  `SDEH_ASSERT_NXT(a_accept_busy, accept, busy)
  `SDEH_ASSERT_IMP(a_result_idle, out_valid_r, state_r == ST_IDLE)
  `SDEH_ASSERT_NXT(a_single_pulse, out_valid_r, !out_valid_r)
  `SDEH_ASSERT_IMP(a_idx_range, state_r == ST_LOOP, idx_r <= IDX_W'(NUM_SWITCHES - 1))

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for switch_debounce_edge_hold
// Drives sample, query and spare-code commands into the debouncer, predicts
// the answer and debounced states of every command with an in-bench model
// of the integrating counters, edge latches and hold timer, and checks each
// result strobe against the oldest outstanding prediction. Runs a directed
// table first, then several register settings with bouncing switch traffic.
// ----------------------------------------------------------------------------
module tb;
  import sdeh_pkg::*;

  localparam int NUM_SW = NUM_SWITCHES_DEF;

  // Spare operation codes: answer zero and leave the state alone
  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  localparam int DIRECTED_ROWS  = 25;
  localparam int PHASES         = 5;
  localparam int RANDOM_PHASE   = 3;   // registers drawn at random in this one
  localparam int QUIET_TAIL     = 120; // final transactions sent without gaps
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic              answer;
    logic [RAW_W-1:0]  states;
  } verdict_t;

  // One command; pinned rows carry a result typed in by hand
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [RAW_W-1:0]   raw;
    logic [TIME_W-1:0]  now;
    logic [SWNUM_W-1:0] sw;
    logic [TIME_W-1:0]  hold;
    logic               pinned;
    logic               answer;
    logic [RAW_W-1:0]   states;
  } cmd_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [OP_W-1:0]        in_operation = OP_SAMPLE;
  logic [RAW_W-1:0]       in_raw_levels = '0;
  logic [TIME_W-1:0]      in_time_now = '0;
  logic [SWNUM_W-1:0]     in_switch_number = '0;
  logic [TIME_W-1:0]      in_hold_ms = '0;
  logic                   out_valid;
  logic                   out_answer;
  logic [RAW_W-1:0]       out_debounced_states;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_COUNTER_TOP;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Pinned expectation travels with the command it belongs to
  logic                   row_pinned = 1'b0;
  logic                   row_answer = 1'b0;
  logic [RAW_W-1:0]       row_states = '0;

  // Shadow of the debouncer
  logic [CNT_W-1:0]       top_cfg;
  logic [PER_W-1:0]       period_cfg;
  logic [CNT_W-1:0]       integ [NUM_SW];
  logic                   active [NUM_SW];
  logic                   rise_seen [NUM_SW];
  logic                   fall_seen [NUM_SW];
  logic [TIME_W-1:0]      held_since [NUM_SW];
  logic [TIME_W-1:0]      next_sample_at;

  verdict_t               pending_verdicts [$];
  int                     mismatch_count = 0;
  int                     quiet_cycles = 0;

  // Directed table: reset reads, spare codes and bad switch numbers are
  // pinned; the debounce sequence and hold tests go through the shadow.
  cmd_row_t directed_cmds [DIRECTED_ROWS] = '{
    '{OP_READ_STATE, 4'h0, 32'd0,          4'd1,  32'd0,          1'b1, 1'b0, 4'h0},
    '{OP_SAMPLE,     4'h0, 32'd0,          4'd0,  32'd0,          1'b1, 1'b0, 4'h0},
    '{OP_RSVD_5,     4'hF, 32'd100,        4'd1,  32'd0,          1'b1, 1'b0, 4'h0},
    '{OP_RSVD_6,     4'hF, 32'd100,        4'd2,  32'd0,          1'b1, 1'b0, 4'h0},
    '{OP_RSVD_7,     4'hF, 32'hFFFF_FFFF,  4'd4,  32'hFFFF_FFFF,  1'b1, 1'b0, 4'h0},
    '{OP_READ_STATE, 4'hF, 32'd0,          4'd0,  32'd0,          1'b1, 1'b0, 4'h0},
    '{OP_READ_STATE, 4'hF, 32'd0,          4'd15, 32'd0,          1'b1, 1'b0, 4'h0},
    '{OP_READ_RISE,  4'h0, 32'd0,          4'd1,  32'd0,          1'b1, 1'b0, 4'h0},
    '{OP_READ_FALL,  4'h0, 32'd0,          4'd4,  32'd0,          1'b1, 1'b0, 4'h0},
    '{OP_HOLD_TEST,  4'h0, 32'd1000,       4'd1,  32'd0,          1'b1, 1'b0, 4'h0},
    '{OP_SAMPLE,     4'hF, 32'd1,          4'd0,  32'd0,          1'b0, 1'b0, 4'h0},
    '{OP_SAMPLE,     4'hF, 32'd7,          4'd0,  32'd0,          1'b0, 1'b0, 4'h0},
    '{OP_SAMPLE,     4'hF, 32'd13,         4'd0,  32'd0,          1'b0, 1'b0, 4'h0},
    '{OP_SAMPLE,     4'hF, 32'd19,         4'd0,  32'd0,          1'b0, 1'b0, 4'h0},
    '{OP_SAMPLE,     4'hF, 32'd25,         4'd0,  32'd0,          1'b0, 1'b0, 4'h0},
    '{OP_READ_STATE, 4'h0, 32'd26,         4'd4,  32'd0,          1'b0, 1'b0, 4'h0},
    '{OP_READ_RISE,  4'h0, 32'd26,         4'd1,  32'd0,          1'b0, 1'b0, 4'h0},
    '{OP_READ_RISE,  4'h0, 32'd27,         4'd1,  32'd0,          1'b0, 1'b0, 4'h0},
    '{OP_HOLD_TEST,  4'h0, 32'd30,         4'd2,  32'd0,          1'b0, 1'b0, 4'h0},
    '{OP_HOLD_TEST,  4'h0, 32'd50,         4'd2,  32'd100,        1'b0, 1'b0, 4'h0},
    '{OP_HOLD_TEST,  4'h0, 32'hFFFF_FFFF,  4'd3,  32'hFFFF_FFFF,  1'b0, 1'b0, 4'h0},
    '{OP_SAMPLE,     4'h0, 32'hFFFF_FFFF,  4'd0,  32'd0,          1'b0, 1'b0, 4'h0},
    '{OP_SAMPLE,     4'h5, 32'd5,          4'd0,  32'd0,          1'b0, 1'b0, 4'h0},
    '{OP_READ_FALL,  4'h0, 32'd6,          4'd2,  32'd0,          1'b0, 1'b0, 4'h0},
    '{OP_HOLD_TEST,  4'h0, 32'hFFFF_FFFF,  4'd1,  32'd0,          1'b0, 1'b0, 4'h0}
  };

  int unsigned phase_top    [PHASES] = '{1, 255, 2, 0, 3};
  int unsigned phase_period [PHASES] = '{0, 1, 65535, 0, 3};
  int          phase_len    [PHASES] = '{200, 560, 180, 150, 180};

  switch_debounce_edge_hold dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_operation         (in_operation),
    .in_raw_levels        (in_raw_levels),
    .in_time_now          (in_time_now),
    .in_switch_number     (in_switch_number),
    .in_hold_ms           (in_hold_ms),
    .out_valid            (out_valid),
    .out_answer           (out_answer),
    .out_debounced_states (out_debounced_states),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advance the shadow by one command and return what the block must answer.
  function automatic void debounce_step(
    input  logic [OP_W-1:0]    op,
    input  logic [RAW_W-1:0]   raw,
    input  logic [TIME_W-1:0]  now,
    input  logic [SWNUM_W-1:0] sw,
    input  logic [TIME_W-1:0]  hold,
    output logic               answer,
    output logic [RAW_W-1:0]   states
  );
    int k;
    answer = 1'b0;
    if (op == OP_SAMPLE) begin
      // Skip the sample unless its time is strictly past the next slot
      if (now > next_sample_at) begin
        next_sample_at = now + TIME_W'(period_cfg);
        for (k = 0; k < NUM_SW; k++) begin
          if (k < RAW_W && raw[k]) begin
            if (integ[k] < top_cfg) integ[k] = integ[k] + 1'b1;
          end else if (integ[k] > 0) begin
            integ[k] = integ[k] - 1'b1;
          end
          if (integ[k] >= top_cfg) begin
            if (!active[k]) begin
              rise_seen[k]  = 1'b1;
              fall_seen[k]  = 1'b0;
              held_since[k] = now;
            end
            active[k] = 1'b1;
          end else if (integ[k] == 0) begin
            if (active[k]) begin
              rise_seen[k]  = 1'b0;
              fall_seen[k]  = 1'b1;
              held_since[k] = HOLD_NONE;
            end
            active[k] = 1'b0;
          end
        end
      end
    end else if (op <= OP_HOLD_TEST && sw >= 1 && sw <= NUM_SW) begin
      k = int'(sw) - 1;
      case (op)
        OP_READ_STATE: answer = active[k];
        OP_READ_RISE: begin
          answer = rise_seen[k];
          rise_seen[k] = 1'b0;
        end
        OP_READ_FALL: begin
          answer = fall_seen[k];
          fall_seen[k] = 1'b0;
        end
        default: begin
          // Hold test: a pass restarts the hold from now
          if (active[k] && now >= hold && (now - hold) > held_since[k]) begin
            held_since[k] = now;
            answer = 1'b1;
          end
        end
      endcase
    end
    states = '0;
    for (k = 0; k < NUM_SW && k < RAW_W; k++) states[k] = active[k];
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
  endtask

  // Track every handshake at the clock edge: check results, predict accepted
  // commands, mirror register writes, and watch for a stalled run.
  always @(posedge clk) begin : monitor
    verdict_t   want;
    logic       answer;
    logic [RAW_W-1:0] states;
    bit         moved;
    int         k;
    moved = 1'b0;
    if (!rst_n) begin
      top_cfg        = COUNTER_TOP_RST;
      period_cfg     = SAMPLE_PERIOD_RST;
      next_sample_at = '0;
      for (k = 0; k < NUM_SW; k++) begin
        integ[k]      = '0;
        active[k]     = 1'b0;
        rise_seen[k]  = 1'b0;
        fall_seen[k]  = 1'b0;
        held_since[k] = HOLD_NONE;
      end
    end else begin
      // Retire the result first; a new command may be taken in the same cycle
      if (out_valid) begin
        moved = 1'b1;
        if (pending_verdicts.size() == 0) begin
          flag_mismatch("result with nothing pending", 32'd0, 32'(out_answer));
        end else begin
          want = pending_verdicts.pop_front();
          if (out_answer !== want.answer)
            flag_mismatch("answer", 32'(want.answer), 32'(out_answer));
          if (out_debounced_states !== want.states)
            flag_mismatch("debounced_states", 32'(want.states), 32'(out_debounced_states));
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        debounce_step(in_operation, in_raw_levels, in_time_now, in_switch_number,
                      in_hold_ms, answer, states);
        if (row_pinned) begin
          answer = row_answer;
          states = row_states;
        end
        pending_verdicts.push_back('{answer, states});
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          REG_COUNTER_TOP:   top_cfg = cfg_data[CNT_W-1:0];
          REG_SAMPLE_PERIOD: period_cfg = cfg_data[PER_W-1:0];
          default: ;
        endcase
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one command and hold it until the block takes the transaction.
  task automatic send_cmd(input cmd_row_t c);
    start            <= 1'b1;
    in_operation     <= c.op;
    in_raw_levels    <= c.raw;
    in_time_now      <= c.now;
    in_switch_number <= c.sw;
    in_hold_ms       <= c.hold;
    row_pinned       <= c.pinned;
    row_answer       <= c.answer;
    row_states       <= c.states;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop start and wait until every pending result has come back.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; hold valid until each is taken.
  task automatic set_config(input logic [CNT_W-1:0] top, input logic [PER_W-1:0] period);
    cfg_valid <= 1'b1;
    cfg_index <= REG_COUNTER_TOP;
    cfg_data  <= CFG_DATA_W'(top);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_SAMPLE_PERIOD;
    cfg_data  <= period;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pick a query operation; rising and falling reads are spread evenly.
  function automatic logic [OP_W-1:0] OP_OP_PICK(input int roll);
    case (roll % 4)
      0:       return OP_READ_STATE;
      1:       return OP_READ_RISE;
      2:       return OP_READ_FALL;
      default: return OP_HOLD_TEST;
    endcase
  endfunction

  initial begin : stimulus
    cmd_row_t    c;
    int          ph;
    int          i;
    int          roll;
    int unsigned top;
    int unsigned period;
    int unsigned step;
    logic [TIME_W-1:0] sim_time;
    logic [RAW_W-1:0]  held_raw;
    bit          gaps_on;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset register values
    for (i = 0; i < DIRECTED_ROWS; i++) send_cmd(directed_cmds[i]);

    // Keep time moving forward across phases so samples keep landing
    sim_time = 32'd100;
    gaps_on  = 1'b1;
    for (ph = 0; ph < PHASES; ph++) begin
      top    = phase_top[ph];
      period = phase_period[ph];
      if (ph == RANDOM_PHASE) begin
        top    = $urandom_range(1, 255);
        period = $urandom_range(0, 65535);
      end
      drain();
      set_config(CNT_W'(top), PER_W'(period));
      // Start the deep-counter phase fully pressed so the switches can reach top
      held_raw = (top > 100) ? 4'hF : RAW_W'($urandom_range(0, 15));

      for (i = 0; i < phase_len[ph]; i++) begin
        c = '0;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 2 * top + 6) == 0) held_raw = RAW_W'($urandom_range(0, 15));
        if (roll < 58) begin
          // Sample with contact bounce on top of the held level
          c.op  = OP_SAMPLE;
          c.raw = held_raw;
          if ($urandom_range(0, 5) == 0) c.raw[$urandom_range(0, RAW_W - 1)] ^= 1'b1;
          if (roll < 3) begin
            c.now = sim_time - $urandom_range(0, 50);
          end else begin
            if ($urandom_range(0, 3) == 0) step = $urandom_range(0, 2);
            else step = $urandom_range(period / 2, period + period / 8 + 2);
            sim_time = sim_time + step;
            c.now = sim_time;
          end
          c.sw   = SWNUM_W'($urandom_range(0, 15));
          c.hold = $urandom;
        end else if (roll < 94) begin
          c.op  = OP_OP_PICK(roll);
          c.raw = RAW_W'($urandom_range(0, 15));
          c.sw  = ($urandom_range(0, 7) == 0) ? SWNUM_W'($urandom_range(0, 15))
                                              : SWNUM_W'($urandom_range(1, NUM_SW));
          c.now = ($urandom_range(0, 15) == 0) ? $urandom : sim_time;
          c.hold = ($urandom_range(0, 7) == 0) ? $urandom
                                               : $urandom_range(0, 4 * period + 40);
        end else begin
          c.op   = OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
          c.raw  = RAW_W'($urandom_range(0, 15));
          c.now  = $urandom;
          c.sw   = SWNUM_W'($urandom_range(0, 15));
          c.hold = $urandom;
        end
        send_cmd(c);

        // Idle in bursts, with whole stretches left back to back
        if (i % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
        if (gaps_on && $urandom_range(0, 2) == 0 &&
            !(ph == PHASES - 1 && i >= phase_len[ph] - QUIET_TAIL))
          idle_cycles($urandom_range(1, 13));
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
